/* src/psmb_pkg.sv */
// ----------------------------------------------------------------------------
// Packed subword memory bank: shared package
// Payload types, action and status codes, and controller/datapath interface
// structs shared by every file of the bank.
// ----------------------------------------------------------------------------
package psmb_pkg;

    // Default bank depth in words.
    localparam int DEPTH_DEF = 4096;

    // Fixed field widths.
    localparam int WORD_W     = 32;
    localparam int IDX_W      = 18;
    localparam int SIZE_OUT_W = 13;
    localparam int CFG_W      = 13;

    // Largest supported subword width code (16 bits).
    localparam logic [2:0] MAX_WIDTH_CODE = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_AUTO_GROW = 1'b0;
    localparam logic CFG_INIT_SIZE = 1'b1;

    // Requested action.
    typedef enum logic [2:0] {
        ACT_RD_WORD = 3'd0,
        ACT_WR_WORD = 3'd1,
        ACT_RD_SUB  = 3'd2,
        ACT_WR_SUB  = 3'd3,
        ACT_FILL    = 3'd4,
        ACT_RESIZE  = 3'd5,
        ACT_INIT    = 3'd6,
        ACT_UNUSED  = 3'd7
    } t_action;

    // Result status.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_ORDER    = 3'd2,
        ST_FILL_END = 3'd3,
        ST_WIDE     = 3'd4,
        ST_CAPACITY = 3'd5,
        ST_WIDTH    = 3'd6
    } t_status;

    // One input beat.
    typedef struct packed {
        t_action                   action;
        logic [IDX_W-1:0]          index;
        logic [IDX_W-1:0]          range_end;
        logic signed [WORD_W-1:0]  write_value;
        logic [2:0]                width_code;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic signed [WORD_W-1:0]  read_data;
        logic [SIZE_OUT_W-1:0]     current_size;
        t_status                   status;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input item
        logic commit;   // apply size change, word write, walk setup
        logic second;   // read data is back: subword merge or read result
        logic walk;     // write one word of the current walk
        logic finish;   // capture the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_action action;
        logic    ok;
        logic    walk_go;
        logic    walk_last;
    } t_dp_stat;

    // Value mask of a subword of width 1 << code bits.
    function automatic logic [WORD_W-1:0] sub_mask(input logic [2:0] code);
        logic [WORD_W-1:0] m;
        case (code)
            3'd0:    m = 32'h0000_0001;
            3'd1:    m = 32'h0000_0003;
            3'd2:    m = 32'h0000_000F;
            3'd3:    m = 32'h0000_00FF;
            3'd4:    m = 32'h0000_FFFF;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

/* src/psmb_ctrl.sv */
// ----------------------------------------------------------------------------
// Packed subword memory bank: controller
// Sequences the clearing pass after reset, evaluation, the read and
// read-modify-write step, and range walks for fill, shrink and init.
// ----------------------------------------------------------------------------
module psmb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  psmb_pkg::t_dp_stat  i_stat,
    output psmb_pkg::t_dp_cmd   o_cmd,
    output logic                o_done
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_READ,
        S_WALK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   needs_read;

    // Reads and subword writes need the stored word back first.
    assign needs_read = (i_stat.action == psmb_pkg::ACT_RD_WORD) ||
                        (i_stat.action == psmb_pkg::ACT_RD_SUB)  ||
                        (i_stat.action == psmb_pkg::ACT_WR_SUB);

    // Commands and next state.
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.commit = 1'b1;
                if (i_stat.ok && needs_read) begin
                    n_state = S_READ;
                end else if (i_stat.ok && i_stat.walk_go) begin
                    n_state = S_WALK;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.second = 1'b1;
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.finish;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

    // An accepted beat makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // Results never come in two adjacent cycles.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // A result is shown only once the block is free again.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

endmodule

/* src/psmb_dp.sv */
// ----------------------------------------------------------------------------
// Packed subword memory bank: datapath
// Word memory, size and configuration registers, action checks, subword
// extract and merge, and the range walk pointer.
// ----------------------------------------------------------------------------
module psmb_dp #(
    parameter int DEPTH = psmb_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psmb_pkg::t_item               i_item,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [psmb_pkg::CFG_W-1:0]    i_cfg_data,
    input  psmb_pkg::t_dp_cmd             i_cmd,
    output psmb_pkg::t_dp_stat            o_stat,
    output psmb_pkg::t_result             o_result
);

    localparam int SW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (SW > 23) ? SW + 1 : 24;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Registers.
    psmb_pkg::t_item   r_item;
    psmb_pkg::t_result r_res;
    logic [SW-1:0]     r_size;
    logic              r_auto_grow;
    logic [12:0]       r_init_size;
    logic [SW-1:0]     r_ptr;
    logic [SW-1:0]     r_wend;
    logic [31:0]       r_wval;
    logic [31:0]       r_mem [DEPTH];
    logic [31:0]       r_rdata;

    // Decode signals.
    psmb_pkg::t_status st;
    logic [CW-1:0]     idx_c;
    logic [CW-1:0]     end_c;
    logic [CW-1:0]     size_c;
    logic [CW-1:0]     need_c;
    logic [CW-1:0]     new_size;
    logic [CW-1:0]     walk_lo;
    logic [CW-1:0]     walk_hi;
    logic [31:0]       walk_val;
    logic              walk_go;
    logic [31:0]       val_u;
    logic [31:0]       mask;
    logic [4:0]        sub_shift;
    logic [AW-1:0]     word_addr;
    logic              ok;
    logic [31:0]       sub_data;
    logic [31:0]       merged;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [31:0]       mem_wdata;
    logic [CW-1:0]     res_size;
    logic [31:0]       res_data;

    assign idx_c  = CW'(r_item.index);
    assign end_c  = CW'(r_item.range_end);
    assign size_c = CW'(r_size);
    assign val_u  = $unsigned(r_item.write_value);
    assign mask   = psmb_pkg::sub_mask(r_item.width_code);

    // Words covered by subwords 0..index: ceil((index + 1) * bits / 32).
    assign need_c = (((idx_c + CW'(1)) << r_item.width_code) + CW'(31)) >> 5;

    // Subword position: the low bits of index pick the lane inside the word.
    assign sub_shift = 5'(idx_c << r_item.width_code);
    always_comb begin
        if ((r_item.action == psmb_pkg::ACT_RD_SUB) ||
            (r_item.action == psmb_pkg::ACT_WR_SUB)) begin
            word_addr = AW'(idx_c >> (3'd5 - r_item.width_code));
        end else begin
            word_addr = AW'(idx_c);
        end
    end

    // Action checks and the resulting size change and walk.
    always_comb begin
        st       = psmb_pkg::ST_OK;
        new_size = size_c;
        walk_lo  = '0;
        walk_hi  = '0;
        walk_val = '0;
        walk_go  = 1'b0;
        case (r_item.action)
            psmb_pkg::ACT_RD_WORD, psmb_pkg::ACT_WR_WORD: begin
                if (idx_c >= size_c) begin
                    if (!r_auto_grow) begin
                        st = psmb_pkg::ST_RANGE;
                    end else if (idx_c + CW'(1) > DEPTH_C) begin
                        st = psmb_pkg::ST_CAPACITY;
                    end else begin
                        new_size = idx_c + CW'(1);
                    end
                end
            end
            psmb_pkg::ACT_RD_SUB, psmb_pkg::ACT_WR_SUB: begin
                if (r_item.width_code > psmb_pkg::MAX_WIDTH_CODE) begin
                    st = psmb_pkg::ST_WIDTH;
                end else if ((r_item.action == psmb_pkg::ACT_WR_SUB) &&
                             (val_u > mask)) begin
                    st = psmb_pkg::ST_WIDE;
                end else if (need_c > size_c) begin
                    if (need_c > DEPTH_C) begin
                        st = psmb_pkg::ST_CAPACITY;
                    end else begin
                        new_size = need_c;
                    end
                end
            end
            psmb_pkg::ACT_FILL: begin
                if (idx_c > end_c) begin
                    st = psmb_pkg::ST_ORDER;
                end else if (end_c > size_c) begin
                    st = psmb_pkg::ST_FILL_END;
                end else begin
                    walk_lo  = idx_c;
                    walk_hi  = end_c;
                    walk_val = val_u;
                    walk_go  = (idx_c < end_c);
                end
            end
            psmb_pkg::ACT_RESIZE: begin
                if (idx_c > DEPTH_C) begin
                    st = psmb_pkg::ST_CAPACITY;
                end else begin
                    // Shrinking clears the dropped words so growth shows zeros.
                    new_size = idx_c;
                    walk_lo  = idx_c;
                    walk_hi  = size_c;
                    walk_go  = (idx_c < size_c);
                end
            end
            psmb_pkg::ACT_INIT: begin
                if (CW'(r_init_size) > DEPTH_C) begin
                    st = psmb_pkg::ST_CAPACITY;
                end else begin
                    // Words past the size are already zero.
                    new_size = CW'(r_init_size);
                    walk_hi  = size_c;
                    walk_go  = (size_c != '0);
                end
            end
            default: begin
                st = psmb_pkg::ST_RANGE;
            end
        endcase
    end

    assign ok = (st == psmb_pkg::ST_OK);

    assign o_stat.action    = r_item.action;
    assign o_stat.ok        = ok;
    assign o_stat.walk_go   = walk_go;
    assign o_stat.walk_last = ((r_ptr + SW'(1)) == r_wend);

    // Subword extract and merge on the word read back.
    assign sub_data = (r_rdata >> sub_shift) & mask;
    assign merged   = (r_rdata & ~(mask << sub_shift)) | (val_u << sub_shift);

    // Memory write port select.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = word_addr;
        mem_wdata = val_u;
        if (i_cmd.walk) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(r_ptr);
            mem_wdata = r_wval;
        end else if (i_cmd.commit && ok &&
                     (r_item.action == psmb_pkg::ACT_WR_WORD)) begin
            mem_we = 1'b1;
        end else if (i_cmd.second && (r_item.action == psmb_pkg::ACT_WR_SUB)) begin
            mem_we    = 1'b1;
            mem_wdata = merged;
        end
    end

    // Word memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[word_addr];
    end

    // Result fields.
    always_comb begin
        res_size = (i_cmd.commit && ok) ? new_size : size_c;
        res_data = '0;
        if (i_cmd.second) begin
            if (r_item.action == psmb_pkg::ACT_RD_WORD) begin
                res_data = r_rdata;
            end else if (r_item.action == psmb_pkg::ACT_RD_SUB) begin
                res_data = sub_data;
            end
        end
    end

    // Control registers: size, configuration and walk pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= '0;
            r_auto_grow <= 1'b0;
            r_init_size <= '0;
            r_ptr       <= '0;
            r_wend      <= SW'(DEPTH);
            r_wval      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == psmb_pkg::CFG_AUTO_GROW) begin
                    r_auto_grow <= i_cfg_data[0];
                end else begin
                    r_init_size <= i_cfg_data[12:0];
                end
            end
            if (i_cmd.commit && ok) begin
                r_size <= SW'(new_size);
                if (walk_go) begin
                    r_ptr  <= SW'(walk_lo);
                    r_wend <= SW'(walk_hi);
                    r_wval <= walk_val;
                end
            end else if (i_cmd.walk) begin
                r_ptr <= r_ptr + SW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.finish) begin
            r_res.read_data    <= signed'(res_data);
            r_res.current_size <= psmb_pkg::SIZE_OUT_W'(res_size);
            r_res.status       <= st;
        end
    end

    assign o_result = r_res;

    // The size never passes the capacity.
    a_size_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_size) <= DEPTH_C)
        else $error("bank size above capacity");

    // A walk write always lands inside its range.
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk |-> (r_ptr < r_wend))
        else $error("walk pointer past range end");

    // The read-back step always follows an evaluation.
    a_second_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.second |-> $past(i_cmd.commit))
        else $error("read-back step without evaluation");

endmodule

/* src/packed_subword_memory_bank.sv */
// ----------------------------------------------------------------------------
// Packed subword memory bank
// A bank of 32-bit words with a current size, packed subword access,
// range fill, resize and init, built as a controller and a datapath.
// ----------------------------------------------------------------------------
// Sequence: word writes, resize upward, empty walks and every error finish
// straight from evaluation; word reads and subword reads and writes add a
// read step, needed by the registered read port of the word memory. Fill,
// shrinking resize and init add a walk over the words in their range. A new
// beat can be taken at the edge that ends the o_done cycle, never while busy.
// After reset, busy stays high while a clearing walk zeroes memory; no stalls.
module packed_subword_memory_bank #(
    parameter int DEPTH = psmb_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  psmb_pkg::t_item               i_item,
    output logic                          o_done,
    output psmb_pkg::t_result             o_result,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [psmb_pkg::CFG_W-1:0]    i_cfg_data
);

    psmb_pkg::t_dp_cmd  cmd;
    psmb_pkg::t_dp_stat stat;

    // Sequencer.
    psmb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_done  (o_done)
    );

    // Memory and arithmetic.
    psmb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_result   (o_result)
    );

endmodule
